>>> rtl/swac_pkg.sv
// ----------------------------------------------------------------------------
// swac_pkg: shared types and constants for the swept box collision classifier
// Widths of coordinates and times, hit codes, and request payload structs.
// ----------------------------------------------------------------------------
package swac_pkg;

  // coordinate and time formats
  localparam int COORD_WIDTH     = 24;
  localparam int COORD_FRAC_BITS = 8;
  localparam int TIME_FRAC_BITS  = 16;

  localparam int SIZE_W = COORD_WIDTH - 1;      // unsigned width/height
  localparam int VEL_W  = COORD_WIDTH + 1;      // velocity after truncation
  localparam int EXT_W  = COORD_WIDTH + 3;      // edge sums and gaps
  localparam int QB     = TIME_FRAC_BITS + 2;   // quotient bits per division
  localparam int TW     = TIME_FRAC_BITS + 3;   // signed time incl. infinities
  localparam int TU     = TIME_FRAC_BITS + 1;   // unsigned Q1 time

  localparam logic [TU-1:0]        TIME_ONE   = TU'(64'd1 << TIME_FRAC_BITS);
  localparam logic signed [TW-1:0] T_ONE      = TW'(64'd1 << TIME_FRAC_BITS);
  localparam logic signed [TW-1:0] T_POS_INF  = TW'(64'd1 << (TIME_FRAC_BITS + 1));
  localparam logic signed [TW-1:0] T_NEG_INF  = -T_POS_INF;
  localparam logic [QB:0]          T_SAT_MAG  = (QB+1)'((64'd1 << (TIME_FRAC_BITS + 1)) - 1);
  localparam logic [VEL_W-1:0]     VEL_KEEP   =
    ~(VEL_W'((64'd1 << COORD_FRAC_BITS) - 64'd1));

  // result codes
  localparam logic [2:0] HIT_NONE   = 3'd0;
  localparam logic [2:0] HIT_POS_X  = 3'd1;
  localparam logic [2:0] HIT_NEG_X  = 3'd2;
  localparam logic [2:0] HIT_POS_Y  = 3'd3;
  localparam logic [2:0] HIT_NEG_Y  = 3'd4;
  localparam logic [2:0] HIT_STATIC = 3'd5;

  typedef struct packed {
    logic                          func;
    logic                          restart;
    logic signed [COORD_WIDTH-1:0] mover_x;
    logic signed [COORD_WIDTH-1:0] mover_y;
    logic [SIZE_W-1:0]             mover_w;
    logic [SIZE_W-1:0]             mover_h;
    logic signed [COORD_WIDTH-1:0] mover_vx;
    logic signed [COORD_WIDTH-1:0] mover_vy;
    logic signed [COORD_WIDTH-1:0] block_x;
    logic signed [COORD_WIDTH-1:0] block_y;
    logic [SIZE_W-1:0]             block_w;
    logic [SIZE_W-1:0]             block_h;
  } in_t;

  typedef struct packed {
    logic [2:0]    hit_code;
    logic [TU-1:0] entry_time;
    logic [TU-1:0] earliest_time;
  } out_t;

endpackage

>>> rtl/swac_div.sv
// ----------------------------------------------------------------------------
// swac_div: radix-2 restoring divider for collision times
// Computes floor(num * 2^TIME_FRAC_BITS / den), saturated, one bit a cycle.
// ----------------------------------------------------------------------------
module swac_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [swac_pkg::EXT_W-1:0] num,
  input  logic signed [swac_pkg::VEL_W-1:0] den,
  output logic                             done,
  output logic signed [swac_pkg::TW-1:0]   quot
);
  import swac_pkg::*;

  localparam int CNT_W = $clog2(QB);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [QB-1:0]    q;
  logic [QB-1:0]    sh;
  logic [VEL_W-1:0] r;
  logic [VEL_W-1:0] ad;
  logic             neg;
  logic             ovf;

  logic [EXT_W-1:0] an_c;
  logic [VEL_W-1:0] ad_c;
  logic             ovf_c;
  logic [VEL_W:0]   rs;
  logic [VEL_W:0]   diff;
  logic             ge;
  logic [QB:0]      c;
  logic [QB:0]      mag;

  // operand magnitudes; quotient of 2^QB or more saturates
  assign an_c  = num[EXT_W-1] ? EXT_W'(-num) : EXT_W'(num);
  assign ad_c  = den[VEL_W-1] ? VEL_W'(-den) : VEL_W'(den);
  assign ovf_c = {1'b0, an_c} >= (EXT_W+1)'({ad_c, 2'b00});

  // one restoring step
  assign rs   = {r, sh[QB-1]};
  assign diff = rs - {1'b0, ad};
  assign ge   = rs >= {1'b0, ad};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      r   <= VEL_W'(an_c >> 2);
      sh  <= {an_c[1:0], {TIME_FRAC_BITS{1'b0}}};
      q   <= '0;
      ad  <= ad_c;
      neg <= num[EXT_W-1] ^ den[VEL_W-1];
      ovf <= ovf_c;
    end else if (busy) begin
      r  <= ge ? VEL_W'(diff) : VEL_W'(rs);
      sh <= sh << 1;
      q  <= {q[QB-2:0], ge};
    end
  end

  // floor for negative quotients, then saturate
  assign c    = {1'b0, q} + (QB+1)'(neg && (r != '0));
  assign mag  = (ovf || c > T_SAT_MAG) ? T_SAT_MAG : c;
  assign quot = neg ? -$signed(mag) : $signed(mag);

endmodule

>>> rtl/swept_aabb_collision_classify_unit.sv
// ----------------------------------------------------------------------------
// swept_aabb_collision_classify_unit: swept box vs. block hit classifier
// Flow: truncate velocities, compute edges and gaps; only when the swept box
// overlaps the block do the four axis times go in turn through the shared divider
// (start, 18 quotient bits, done), and a zero velocity axis skips it; then decide.
// One request at a time; an output stall holds the next one back.
// Reset sets the earliest hit time to 1.0 and empties the output register.
// ----------------------------------------------------------------------------
module swept_aabb_collision_classify_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  swac_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output swac_pkg::out_t out_data
);
  import swac_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_TRUNC  = 7'b0000010,
    S_PREP   = 7'b0000100,
    S_DIVS   = 7'b0001000,
    S_DWAIT  = 7'b0010000,
    S_DECIDE = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state;

  in_t                     req;
  logic signed [VEL_W-1:0] vx, vy;
  logic signed [EXT_W-1:0] gap [4];
  logic signed [TW-1:0]    tm [4];
  logic                    vx_zero, vy_zero;
  logic                    swept_ov, static_ov;
  logic [1:0]              idx;
  logic [TU-1:0]           min_hit_time;
  logic [2:0]              res_code;
  logic [TU-1:0]           res_time;

  // ---- truncation of velocities in check mode
  logic signed [VEL_W-1:0] vx_e, vy_e, vx_tr, vy_tr;
  assign vx_e  = VEL_W'(req.mover_vx);
  assign vy_e  = VEL_W'(req.mover_vy);
  assign vx_tr = !req.func ? vx_e :
                 (vx_e >= 0 ? (vx_e & VEL_KEEP) : -((-vx_e) & VEL_KEEP));
  assign vy_tr = !req.func ? vy_e :
                 (vy_e >= 0 ? (vy_e & VEL_KEEP) : -((-vy_e) & VEL_KEEP));

  // ---- edges, swept box and gaps
  logic signed [EXT_W-1:0] x, y, w, h, bx, by, bw, bh, vxe, vye;
  logic signed [EXT_W-1:0] px, py, pw, ph;
  logic signed [EXT_W-1:0] gxe, gxx, gye, gyx;
  logic                    sw_ov_c, st_ov_c;

  assign x   = EXT_W'(req.mover_x);
  assign y   = EXT_W'(req.mover_y);
  assign w   = EXT_W'({1'b0, req.mover_w});
  assign h   = EXT_W'({1'b0, req.mover_h});
  assign bx  = EXT_W'(req.block_x);
  assign by  = EXT_W'(req.block_y);
  assign bw  = EXT_W'({1'b0, req.block_w});
  assign bh  = EXT_W'({1'b0, req.block_h});
  assign vxe = EXT_W'(vx);
  assign vye = EXT_W'(vy);

  assign px = (vx > 0) ? x : x + vxe;
  assign py = (vy > 0) ? y : y + vye;
  assign pw = (vx > 0) ? w + vxe : w - vxe;
  assign ph = (vy > 0) ? h + vye : h - vye;

  assign sw_ov_c = !((px + pw < bx) || (px > bx + bw) || (py + ph < by) || (py > by + bh));
  assign st_ov_c = !((x + w < bx) || (x > bx + bw) || (y + h < by) || (y > by + bh));

  assign gxe = (vx > 0) ? bx - (x + w) : (bx + bw) - x;
  assign gxx = (vx > 0) ? (bx + bw) - x : bx - (x + w);
  assign gye = (vy > 0) ? by - (y + h) : (by + bh) - y;
  assign gyx = (vy > 0) ? (by + bh) - y : by - (y + h);

  // ---- shared divider; idx 0/1 are x entry/exit, 2/3 y entry/exit
  logic                    div_start, div_done;
  logic signed [TW-1:0]    div_quot;
  logic                    axis_zero;

  assign axis_zero = idx[1] ? vy_zero : vx_zero;

  swac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (gap[idx]),
    .den   (idx[1] ? vy : vx),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign div_start = (state == S_DIVS) && !axis_zero;

  // ---- classification
  logic signed [TW-1:0] te, tx;
  logic                 hit, sw_hit;
  logic [2:0]           code_c;

  assign te     = (tm[0] > tm[2]) ? tm[0] : tm[2];
  assign tx     = (tm[1] < tm[3]) ? tm[1] : tm[3];
  assign hit    = !((te > tx) || (tm[0] < 0 && tm[2] < 0) || (tm[0] > T_ONE) || (tm[2] > T_ONE));
  assign sw_hit = swept_ov && hit && (te < T_ONE);

  always_comb begin
    if (sw_hit) begin
      if (tm[0] > tm[2]) code_c = gap[0][EXT_W-1] ? HIT_POS_X : HIT_NEG_X;
      else               code_c = gap[2][EXT_W-1] ? HIT_POS_Y : HIT_NEG_Y;
    end else if (swept_ov && static_ov) begin
      code_c = HIT_STATIC;
    end else begin
      code_c = HIT_NONE;
    end
  end

  assign in_ready = (state == S_IDLE);

  // ---- sequencer and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      min_hit_time <= TIME_ONE;
      idx          <= '0;
    end else begin
      if (state == S_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.restart) min_hit_time <= TIME_ONE;
            state <= S_TRUNC;
          end
        end
        S_TRUNC: state <= S_PREP;
        S_PREP: begin
          idx   <= '0;
          state <= sw_ov_c ? S_DIVS : S_DECIDE;
        end
        S_DIVS: begin
          if (axis_zero) begin
            idx   <= idx + 1'b1;
            state <= (idx == 2'd3) ? S_DECIDE : S_DIVS;
          end else begin
            state <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (div_done) begin
            idx   <= idx + 1'b1;
            state <= (idx == 2'd3) ? S_DECIDE : S_DIVS;
          end
        end
        S_DECIDE: begin
          if (sw_hit && !req.func && ($signed({1'b0, min_hit_time}) > te))
            min_hit_time <= TU'(te);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---- payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) req <= in_data;
    if (state == S_TRUNC) begin
      vx      <= vx_tr;
      vy      <= vy_tr;
      vx_zero <= (vx_tr == '0);
      vy_zero <= (vy_tr == '0);
    end
    if (state == S_PREP) begin
      gap[0]    <= gxe;
      gap[1]    <= gxx;
      gap[2]    <= gye;
      gap[3]    <= gyx;
      swept_ov  <= sw_ov_c;
      static_ov <= st_ov_c;
    end
    if (state == S_DIVS && axis_zero) tm[idx] <= idx[0] ? T_POS_INF : T_NEG_INF;
    if (state == S_DWAIT && div_done) tm[idx] <= div_quot;
    if (state == S_DECIDE) begin
      res_code <= code_c;
      res_time <= sw_hit ? TU'(te) : TIME_ONE;
    end
    if (state == S_OUT && (!out_valid || out_ready)) begin
      out_data.hit_code      <= res_code;
      out_data.entry_time    <= res_time;
      out_data.earliest_time <= min_hit_time;
    end
  end

  // ---- checks
  a_min_range: assert property (@(posedge clk) disable iff (rst)
    min_hit_time <= TIME_ONE) else $error("earliest time above 1.0");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.restart |=> min_hit_time == TIME_ONE)
    else $error("restart did not reset earliest time");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.hit_code <= HIT_STATIC) else $error("bad hit code");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DWAIT) else $error("divider done outside wait");

endmodule
